// File: hdl/rim_pkg.sv
// Shared widths, multiplier operand codes and the command and status types
// that pass between the mixer controller and its datapath.
// No dependencies.
`default_nettype none

package rim_pkg;

  localparam int SAMPLE_W   = 16;  // input sample and mixed outputs, Q1.15
  localparam int OSC_W      = 32;  // oscillator and step registers, Q2.30
  localparam int FRAC_W     = 30;  // fraction bits of the oscillator
  localparam int PROD_W     = 2 * OSC_W;
  localparam int QUO_W      = OSC_W + FRAC_W;  // renormalization quotient
  localparam int SQRT_STEPS = OSC_W;           // one result bit per step
  localparam int DIV_STEPS  = QUO_W;           // one quotient bit per step
  localparam int CNT_W      = $clog2(DIV_STEPS);

  // Operand pairs for the two shared multipliers.
  localparam logic [1:0] MUL_MIX   = 2'd0;  // sample*re, sample*im
  localparam logic [1:0] MUL_ROT_A = 2'd1;  // re*cos,    im*sin
  localparam logic [1:0] MUL_ROT_B = 2'd2;  // im*cos,    re*sin
  localparam logic [1:0] MUL_SQ    = 2'd3;  // re*re,     im*im

  typedef struct packed {
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       mix_ld;
    logic       re_ld;
    logic       im_ld;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       norm_ld;
    logic       out_ld;
  } rim_cmd_t;

  typedef struct packed {
    logic root_zero;
  } rim_sts_t;

endpackage

`default_nettype wire

// File: hdl/recursive_iq_mixer_core.sv
// Top level of the recursive IQ mixer: stream ports, APB register file for
// the rotation step, controller and datapath.
// Depends on rim_pkg, rim_ctrl and rim_dp.
`default_nettype none

// Each input word carries one real Q1.15 sample; the block returns one word
// holding the sample multiplied by the current complex oscillator (Q2.30),
// rounded half up and saturated to Q1.15, then rotates the oscillator by the
// cos_step/sin_step pair. A new word is taken only after the previous one has
// passed the two shared 32x32 multipliers, which each do three products per
// word (mix, then the two rotation pairs). A word marked with in_tlast also
// renormalizes the oscillator to unit magnitude: a squared magnitude, a
// 32-step bit-pair square root and two 62-step restoring dividers. The result
// register lets the next word in while the previous result waits for
// out_tready. cos_step and sin_step sit at byte addresses 0 and 4 and reset
// to 1.0 and 0; write them only while the block is idle.
module recursive_iq_mixer_core
  import rim_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input stream.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [SAMPLE_W-1:0]   in_tdata,   // [15:0] sample
  input  wire logic                  in_tlast,   // last_in_block
  // Result stream.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [2*SAMPLE_W-1:0]      out_tdata,  // [15:0] out_re, [31:16] out_im
  // Configuration port.
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [2:0]            cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  // Register indexes, taken from the word address bit.
  localparam logic REG_COS = 1'b0;
  localparam logic REG_SIN = 1'b1;

  localparam logic [OSC_W-1:0] COS_RESET = OSC_W'(1) << FRAC_W;

  logic [OSC_W-1:0] cos_step_r;
  logic [OSC_W-1:0] sin_step_r;
  logic             cfg_wr;
  logic             reg_idx;
  rim_cmd_t         cmd;
  rim_sts_t         sts;

  // The register is written on the access cycle of a write transfer.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_step_r <= COS_RESET;
      sin_step_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_COS: cos_step_r <= cfg_pwdata;
        REG_SIN: sin_step_r <= cfg_pwdata;
        default: cos_step_r <= cos_step_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COS: cfg_prdata = cos_step_r;
      REG_SIN: cfg_prdata = sin_step_r;
      default: cfg_prdata = '0;
    endcase
  end

  // The controller owns the handshakes; the datapath only follows commands.
  rim_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_last   (in_tlast),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .sts       (sts),
    .cmd       (cmd)
  );

  rim_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cos_step  (cos_step_r),
    .sin_step  (sin_step_r),
    .in_sample (in_tdata),
    .out_data  (out_tdata),
    .sts       (sts)
  );

endmodule

`default_nettype wire

// File: hdl/rim_dp.sv
// Mixer datapath: oscillator state, two shared 32x32 multipliers, rounding,
// bit-pair square root and two restoring dividers for renormalization.
// Depends on rim_pkg.
`default_nettype none

module rim_dp
  import rim_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire rim_cmd_t                   cmd,
  input  wire logic signed [OSC_W-1:0]    cos_step,
  input  wire logic signed [OSC_W-1:0]    sin_step,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  output logic [2*SAMPLE_W-1:0]           out_data,
  output rim_sts_t                        sts
);

  localparam logic signed [PROD_W-1:0] MIX_HALF = PROD_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [PROD_W-1:0] MIX_MAX  = (PROD_W'(1) <<< (SAMPLE_W - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] MIX_MIN  = -(PROD_W'(1) <<< (SAMPLE_W - 1));
  localparam logic signed [PROD_W:0]   ROT_HALF = (PROD_W + 1)'(1) <<< (FRAC_W - 1);
  localparam logic signed [PROD_W:0]   ROT_MAX  = ((PROD_W + 1)'(1) <<< (OSC_W - 1))
                                                  - (PROD_W + 1)'(1);
  localparam logic signed [PROD_W:0]   ROT_MIN  = -((PROD_W + 1)'(1) <<< (OSC_W - 1));
  localparam logic [QUO_W-1:0]         Q_POS_MAX = (QUO_W'(1) << (OSC_W - 1)) - QUO_W'(1);
  localparam logic [QUO_W-1:0]         Q_NEG_MAX = QUO_W'(1) << (OSC_W - 1);
  localparam logic [OSC_W-1:0]         OSC_POS_SAT = {1'b0, {(OSC_W - 1){1'b1}}};
  localparam logic [OSC_W-1:0]         OSC_NEG_SAT = {1'b1, {(OSC_W - 1){1'b0}}};
  localparam logic signed [OSC_W-1:0]  OSC_ONE  = OSC_W'(1) <<< FRAC_W;
  localparam logic [PROD_W-1:0]        BIT_TOP  = PROD_W'(1) << (PROD_W - 2);

  // Round half up, then saturate to a sample.
  function automatic logic [SAMPLE_W-1:0] mix_round(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = (p + MIX_HALF) >>> FRAC_W;
    if (t > MIX_MAX) begin
      return MIX_MAX[SAMPLE_W-1:0];
    end else if (t < MIX_MIN) begin
      return MIX_MIN[SAMPLE_W-1:0];
    end
    return t[SAMPLE_W-1:0];
  endfunction

  // Exact a +/- b, round half up to Q2.30, saturate to 32 bits.
  function automatic logic [OSC_W-1:0] rot_round(input logic signed [PROD_W-1:0] a,
                                                 input logic signed [PROD_W-1:0] b,
                                                 input logic                     sub);
    logic signed [PROD_W:0] ax;
    logic signed [PROD_W:0] bx;
    logic signed [PROD_W:0] t;
    ax = $signed({a[PROD_W-1], a});
    bx = $signed({b[PROD_W-1], b});
    t  = ((sub ? (ax - bx) : (ax + bx)) + ROT_HALF) >>> FRAC_W;
    if (t > ROT_MAX) begin
      return OSC_POS_SAT;
    end else if (t < ROT_MIN) begin
      return OSC_NEG_SAT;
    end
    return t[OSC_W-1:0];
  endfunction

  // Apply the sign to an unsigned quotient and saturate to 32 bits.
  function automatic logic [OSC_W-1:0] quo_sat(input logic neg, input logic [QUO_W-1:0] q);
    if (!neg) begin
      return (q > Q_POS_MAX) ? OSC_POS_SAT : q[OSC_W-1:0];
    end
    return (q > Q_NEG_MAX) ? OSC_NEG_SAT : (~q[OSC_W-1:0] + OSC_W'(1));
  endfunction

  logic signed [OSC_W-1:0]  osc_re_r;
  logic signed [OSC_W-1:0]  osc_im_r;
  logic signed [OSC_W-1:0]  mul_a0, mul_b0, mul_a1, mul_b1;
  logic signed [OSC_W-1:0]  samp_x;
  logic signed [PROD_W-1:0] p0_r, p1_r;
  logic [SAMPLE_W-1:0]      mix_re_r, mix_im_r;
  logic [2*SAMPLE_W-1:0]    out_data_r;

  logic [PROD_W-1:0]        rad_r;    // remaining radicand
  logic [PROD_W-1:0]        res_r;    // root being built
  logic [PROD_W-1:0]        bit_r;    // current bit pair
  logic [PROD_W-1:0]        trial;
  logic [OSC_W-1:0]         root;

  logic [QUO_W-1:0]         dvd_r [2];  // dividend shifting out, quotient in
  logic [OSC_W-1:0]         rem_r [2];
  logic                     neg_r [2];
  logic [OSC_W-1:0]         osc_mag [2];
  logic [OSC_W:0]           div_t [2];
  logic                     div_ge [2];

  assign samp_x = $signed({{(OSC_W - SAMPLE_W){in_sample[SAMPLE_W-1]}}, in_sample});

  always_comb begin
    mul_a0 = osc_re_r;
    mul_b0 = cos_step;
    mul_a1 = osc_im_r;
    mul_b1 = sin_step;
    case (cmd.mul_sel)
      MUL_MIX: begin
        mul_a0 = samp_x;
        mul_b0 = osc_re_r;
        mul_a1 = samp_x;
        mul_b1 = osc_im_r;
      end
      MUL_ROT_A: begin
        mul_a0 = osc_re_r;
        mul_b0 = cos_step;
        mul_a1 = osc_im_r;
        mul_b1 = sin_step;
      end
      MUL_ROT_B: begin
        mul_a0 = osc_im_r;
        mul_b0 = cos_step;
        mul_a1 = osc_re_r;
        mul_b1 = sin_step;
      end
      MUL_SQ: begin
        mul_a0 = osc_re_r;
        mul_b0 = osc_re_r;
        mul_a1 = osc_im_r;
        mul_b1 = osc_im_r;
      end
      default: begin
        mul_a0 = osc_re_r;
        mul_b0 = cos_step;
        mul_a1 = osc_im_r;
        mul_b1 = sin_step;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p0_r <= mul_a0 * mul_b0;
      p1_r <= mul_a1 * mul_b1;
    end
    if (cmd.mix_ld) begin
      mix_re_r <= mix_round(p0_r);
      mix_im_r <= mix_round(p1_r);
    end
    if (cmd.out_ld) begin
      out_data_r <= {mix_im_r, mix_re_r};
    end
  end

  // Square root, one result bit per cycle.
  assign trial = res_r + bit_r;
  assign root  = res_r[OSC_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      rad_r <= p0_r + p1_r;
      res_r <= '0;
      bit_r <= BIT_TOP;
    end else if (cmd.sqrt_step) begin
      if (rad_r >= trial) begin
        rad_r <= rad_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // Two restoring dividers, one per oscillator part, in lockstep.
  assign osc_mag[0] = osc_re_r[OSC_W-1] ? (~osc_re_r + OSC_W'(1)) : osc_re_r;
  assign osc_mag[1] = osc_im_r[OSC_W-1] ? (~osc_im_r + OSC_W'(1)) : osc_im_r;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      div_t[k]  = {rem_r[k], dvd_r[k][QUO_W-1]};
      div_ge[k] = div_t[k] >= {1'b0, root};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      if (cmd.div_init) begin
        dvd_r[k] <= {osc_mag[k], {FRAC_W{1'b0}}};
        rem_r[k] <= '0;
        neg_r[k] <= (k == 0) ? osc_re_r[OSC_W-1] : osc_im_r[OSC_W-1];
      end else if (cmd.div_step) begin
        rem_r[k] <= div_ge[k] ? (div_t[k][OSC_W-1:0] - root) : div_t[k][OSC_W-1:0];
        dvd_r[k] <= {dvd_r[k][QUO_W-2:0], div_ge[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      osc_re_r <= OSC_ONE;
      osc_im_r <= '0;
    end else begin
      if (cmd.re_ld) begin
        osc_re_r <= rot_round(p0_r, p1_r, 1'b1);
      end
      if (cmd.im_ld) begin
        osc_im_r <= rot_round(p0_r, p1_r, 1'b0);
      end
      if (cmd.norm_ld && (root != '0)) begin
        osc_re_r <= quo_sat(neg_r[0], dvd_r[0]);
        osc_im_r <= quo_sat(neg_r[1], dvd_r[1]);
      end
    end
  end

  assign out_data      = out_data_r;
  assign sts.root_zero = (root == '0);

endmodule

`default_nettype wire

// File: hdl/rim_ctrl.sv
// Mixer controller: sequences multiplies, rotation, renormalization and the
// output handshake of one word at a time.
// Depends on rim_pkg.
`default_nettype none

module rim_ctrl
  import rim_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_last,
  output logic          in_ready,
  input  wire logic     out_ready,
  output logic          out_valid,
  input  wire rim_sts_t sts,
  output rim_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ROT0 = 4'd1;
  localparam logic [3:0] S_ROT1 = 4'd2;
  localparam logic [3:0] S_ROT2 = 4'd3;
  localparam logic [3:0] S_SQ   = 4'd4;
  localparam logic [3:0] S_MAG  = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_DVI  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             last_r, last_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_MIX;
          last_nxt    = in_last;
          state_nxt   = S_ROT0;
        end
      end
      S_ROT0: begin
        cmd.mix_ld  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ROT_A;
        state_nxt   = S_ROT1;
      end
      S_ROT1: begin
        cmd.re_ld   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ROT_B;
        state_nxt   = S_ROT2;
      end
      S_ROT2: begin
        // Products are held here, so a stall just rewrites the same value.
        cmd.im_ld = 1'b1;
        if (last_r) begin
          state_nxt = S_SQ;
        end else if (out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SQ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SQ;
        state_nxt   = S_MAG;
      end
      S_MAG: begin
        cmd.sqrt_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DVI;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_DVI: begin
        cmd.div_init = 1'b1;
        state_nxt    = sts.root_zero ? S_FIN : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_FIN: begin
        cmd.norm_ld = 1'b1;
        if (out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: hdl/rim_checker.sv
// Port-level checks for the recursive IQ mixer, bound to its top level.
// Depends on rim_pkg and recursive_iq_mixer_core.
`default_nettype none

module rim_checker
  import rim_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_tvalid,
  input wire logic                 in_tready,
  input wire logic                 out_tvalid,
  input wire logic                 out_tready,
  input wire logic [2*SAMPLE_W-1:0] out_tdata
);

  // A result held back by the sink stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // One word at a time: right after taking a word the block is busy.
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a word is still in work");

  // A new result only shows up from a busy state, never straight from idle.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without a word in work");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind recursive_iq_mixer_core rim_checker u_rim_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for recursive_iq_mixer_core: stream driver, stream
// monitor with a built-in model of the mixer and oscillator, and APB setup.
// Depends on rim_pkg and the recursive_iq_mixer_core RTL.
`default_nettype none

module tb
  import rim_pkg::*;
();

  localparam int HALF_PERIOD  = 10;
  // A marked word hands its result over only once renormalization is done,
  // so the block is idle after the last result; this is an extra idle margin
  // between the last result of a phase and the next register writes.
  localparam int SETTLE_CYCLES = 150;
  localparam int LONG_HOLD     = 400;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_WORDS   = 240;

  // Register map: cos_step at byte 0, sin_step at byte 4.
  localparam logic [2:0] ADDR_COS_STEP = 3'd0;
  localparam logic [2:0] ADDR_SIN_STEP = 3'd4;

  localparam logic signed [OSC_W-1:0] ONE_Q30  = 32'sh4000_0000;
  localparam logic signed [OSC_W-1:0] MONE_Q30 = -32'sh4000_0000;

  typedef enum logic [1:0] {
    PACE_FREE,
    PACE_SEND_GAPS,
    PACE_RECV_STALLS,
    PACE_BOTH
  } pace_t;

  // One input word as it travels on in_tlast and in_tdata.
  typedef struct packed {
    logic                last;
    logic [SAMPLE_W-1:0] sample;
  } in_word_t;

  // One result word as packed on out_tdata, out_re in the low half.
  typedef struct packed {
    logic [SAMPLE_W-1:0] im;
    logic [SAMPLE_W-1:0] re;
  } mix_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [SAMPLE_W-1:0]   in_tdata = '0;    // [15:0] sample
  logic                  in_tlast = 1'b0;  // last_in_block
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [2*SAMPLE_W-1:0] out_tdata;        // [15:0] out_re, [31:16] out_im
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [2:0]            cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  always #HALF_PERIOD clk = ~clk;

  recursive_iq_mixer_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Words waiting to be offered, and mixer outputs waiting to be seen.
  in_word_t  pending_words[$];
  mix_word_t expected_mix[$];

  pace_t pace = PACE_FREE;
  logic  in_taken = 1'b0;
  logic  hold_req = 1'b0;
  logic  hold_active = 1'b0;

  int words_queued = 0;
  int words_accepted = 0;
  int blocks_seen = 0;
  int results_seen = 0;
  int settings_written = 0;
  int err_count = 0;

  // Model copies of the step registers and the oscillator, all Q2.30.
  logic signed [OSC_W-1:0] cos_q = ONE_Q30;
  logic signed [OSC_W-1:0] sin_q = '0;
  logic signed [OSC_W-1:0] osc_re_q = ONE_Q30;
  logic signed [OSC_W-1:0] osc_im_q = '0;

  mix_word_t got_mix, want_mix;

  // ---------------------------------------------------------------------
  // Mixer model. All intermediate values are carried in 66 signed bits,
  // which holds any difference of two 64-bit products plus the rounding
  // constant without overflow.
  // ---------------------------------------------------------------------
  function automatic logic signed [65:0] sat(input logic signed [65:0] x, input int w);
    logic signed [65:0] hi, lo;
    hi = (66'sd1 <<< (w - 1)) - 66'sd1;
    lo = -hi - 66'sd1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // Floor square root, one result bit per pass.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] rem, root, probe;
    rem   = n;
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Sample times one oscillator part, rounded half up, saturated to Q1.15.
  function automatic logic [SAMPLE_W-1:0] mix_part(input logic signed [SAMPLE_W-1:0] s,
                                                   input logic signed [OSC_W-1:0] osc);
    logic signed [65:0] p;
    p = s * osc;
    p = sat((p + (66'sd1 <<< (FRAC_W - 1))) >>> FRAC_W, SAMPLE_W);
    return p[SAMPLE_W-1:0];
  endfunction

  // Returns the mixer output for one word and advances the model oscillator.
  function automatic mix_word_t mix_and_advance(input in_word_t w);
    mix_word_t          res;
    logic signed [65:0] pa, pb, nre, nim, num, den;
    logic [63:0]        root;
    res.re = mix_part(w.sample, osc_re_q);
    res.im = mix_part(w.sample, osc_im_q);

    // Rotation uses the pre-rotation value for both parts.
    pa  = osc_re_q * cos_q;
    pb  = osc_im_q * sin_q;
    nre = sat((pa - pb + (66'sd1 <<< (FRAC_W - 1))) >>> FRAC_W, OSC_W);
    pa  = osc_im_q * cos_q;
    pb  = osc_re_q * sin_q;
    nim = sat((pa + pb + (66'sd1 <<< (FRAC_W - 1))) >>> FRAC_W, OSC_W);

    // Renormalize on the block's last word; a zero root leaves it alone.
    if (w.last) begin
      pa   = nre * nre + nim * nim;
      root = floor_sqrt(pa[63:0]);
      if (root != 0) begin
        den = $signed({2'b00, root});
        num = nre <<< FRAC_W;
        nre = sat(num / den, OSC_W);
        num = nim <<< FRAC_W;
        nim = sat(num / den, OSC_W);
      end
    end
    osc_re_q = nre[OSC_W-1:0];
    osc_im_q = nim[OSC_W-1:0];
    return res;
  endfunction

  // Random back-pressure on either side, depending on the current pace.
  function automatic logic rests(input pace_t own);
    if (pace == own) return $urandom_range(99) < 58;
    if (pace == PACE_BOTH) return $urandom_range(99) < 25;
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input mix_word_t want, input mix_word_t got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("MISMATCH %s: expected re=%0d im=%0d, got re=%0d im=%0d", what,
               $signed(want.re), $signed(want.im), $signed(got.re), $signed(got.im));
  endtask

  // ---------------------------------------------------------------------
  // Input driver. A word stays on the bus until the monitor saw it taken;
  // only then is the next word from the pending queue put up, or the bus
  // left idle when the pace asks for a gap.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (!in_tvalid || in_taken) begin
      if (pending_words.size() != 0 && !rests(PACE_SEND_GAPS)) begin
        {in_tlast, in_tdata} <= pending_words.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver. The long hold overrides the random stalls.
  always @(negedge clk) begin
    out_tready <= !hold_active && !rests(PACE_RECV_STALLS);
  end

  // Long receiver hold, counted in clock cycles here, started on request.
  initial begin
    @(posedge hold_req);
    @(posedge clk);
    hold_active = 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_active = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Monitor. Every accepted input word is run through the model at once,
  // so expectations line up in acceptance order; every accepted result is
  // checked against the oldest one. Register writes update the model copy,
  // and register reads are checked against it.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    in_taken <= in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_mix.push_back(mix_and_advance({in_tlast, in_tdata}));
        words_accepted++;
        if (in_tlast) blocks_seen++;
      end
      if (out_tvalid && out_tready) begin
        got_mix = out_tdata;
        results_seen++;
        if (expected_mix.size() == 0) begin
          report_mismatch("result with nothing pending", '0, got_mix);
        end else begin
          want_mix = expected_mix.pop_front();
          if (got_mix.re !== want_mix.re || got_mix.im !== want_mix.im)
            report_mismatch("result word", want_mix, got_mix);
        end
      end
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          case (cfg_paddr)
            ADDR_COS_STEP: cos_q = cfg_pwdata;
            ADDR_SIN_STEP: sin_q = cfg_pwdata;
            default: ;
          endcase
        end else begin
          case (cfg_paddr)
            ADDR_COS_STEP: if (cfg_prdata !== cos_q) report_mismatch("cos_step read",
                             cos_q, cfg_prdata);
            ADDR_SIN_STEP: if (cfg_prdata !== sin_q) report_mismatch("sin_step read",
                             sin_q, cfg_prdata);
            default: ;
          endcase
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  task automatic apb_access(input logic write, input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Writes both step registers and reads them back.
  task automatic set_step(input logic [31:0] c, input logic [31:0] s);
    apb_access(1'b1, ADDR_COS_STEP, c);
    apb_access(1'b1, ADDR_SIN_STEP, s);
    apb_access(1'b0, ADDR_COS_STEP, '0);
    apb_access(1'b0, ADDR_SIN_STEP, '0);
    settings_written++;
  endtask

  // Called right after a rising edge, so the driver never sees a half-filled
  // queue in the same time step as it pops.
  task automatic push_word(input logic [SAMPLE_W-1:0] s, input logic last);
    pending_words.push_back({last, s});
    words_queued++;
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(15))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Mostly well-formed blocks of random length closed by a marked word,
  // mixed with loose words whose mark is random.
  task automatic push_random_words(input int count);
    int left, run, k;
    left = count;
    @(posedge clk);
    while (left > 0) begin
      if ($urandom_range(99) < 85) begin
        run = $urandom_range(12, 1);
        if (run > left) run = left;
        for (k = 0; k < run; k++) push_word(random_sample(), k == run - 1);
        left -= run;
      end else begin
        push_word(random_sample(), 1'($urandom_range(1)));
        left--;
      end
    end
  endtask

  // Waits until every queued word was taken and every result arrived, then
  // idles for a margin before the next register writes.
  task automatic drain();
    do @(negedge clk); while (words_accepted != words_queued || expected_mix.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // A unit rotation at a random angle.
  task automatic random_rotation(output logic [31:0] c, output logic [31:0] s);
    real ang;
    ang = $urandom_range(62831) / 10000.0;
    c = $rtoi($cos(ang) * 1073741824.0);
    s = $rtoi($sin(ang) * 1073741824.0);
  endtask

  // Any value from -1.0 to 1.0 in Q2.30, gain not limited to one.
  function automatic logic [31:0] any_step();
    return $urandom_range(32'h8000_0000) - 32'h4000_0000;
  endfunction

  task automatic run_phase(input pace_t p, input logic [31:0] c, input logic [31:0] s,
                           input int count);
    set_step(c, s);
    @(posedge clk);
    pace = p;
    push_random_words(count);
    drain();
  endtask

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  initial begin
    logic [31:0] c, s;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values read back, then the sample extremes with a unit
    // oscillator, where out_re must equal the input and out_im must be zero.
    apb_access(1'b0, ADDR_COS_STEP, '0);
    apb_access(1'b0, ADDR_SIN_STEP, '0);
    @(posedge clk);
    push_word(16'h7fff, 1'b0);
    push_word(16'h8000, 1'b0);
    push_word(16'h0000, 1'b0);
    push_word(16'h0001, 1'b1);
    push_word(16'hffff, 1'b0);
    push_word(16'h5555, 1'b0);
    push_word(16'haaaa, 1'b1);
    drain();

    // Quarter turns per word: the oscillator visits both axes.
    set_step('0, ONE_Q30);
    @(posedge clk);
    push_word(16'h7fff, 1'b0);
    push_word(16'h8000, 1'b0);
    push_word(16'h7fff, 1'b0);
    push_word(16'h8000, 1'b1);
    push_word(16'h4000, 1'b0);
    drain();

    // Oversized rotation: the oscillator grows until it saturates and the
    // mixed outputs clip, then a marked word pulls it back to unit size.
    set_step(ONE_Q30, ONE_Q30);
    @(posedge clk);
    push_word(16'h7fff, 1'b0);
    push_word(16'h8000, 1'b0);
    push_word(16'h7fff, 1'b0);
    push_word(16'h8000, 1'b0);
    push_word(16'h7fff, 1'b0);
    push_word(16'h8000, 1'b0);
    push_word(16'h7fff, 1'b0);
    push_word(16'h8000, 1'b1);
    push_word(16'h7fff, 1'b0);
    drain();

    // Random part. The first phase also holds the receiver off for a long
    // stretch while words keep coming, so the input side backs up.
    random_rotation(c, s);
    set_step(c, s);
    @(posedge clk);
    pace = PACE_FREE;
    push_random_words(PHASE_WORDS);
    repeat (50) @(negedge clk);
    hold_req = 1'b1;
    drain();

    run_phase(PACE_SEND_GAPS, MONE_Q30, MONE_Q30, PHASE_WORDS);
    random_rotation(c, s);
    run_phase(PACE_RECV_STALLS, c, s, PHASE_WORDS);
    run_phase(PACE_BOTH, any_step(), any_step(), PHASE_WORDS);
    random_rotation(c, s);
    run_phase(PACE_SEND_GAPS, c, s, PHASE_WORDS);
    run_phase(PACE_RECV_STALLS, MONE_Q30, '0, PHASE_WORDS);

    // Zero step: the oscillator collapses to zero and a marked word with a
    // zero magnitude must leave it there. Nothing can bring it back, so
    // this runs last.
    set_step('0, '0);
    @(posedge clk);
    pace = PACE_FREE;
    push_word(16'h7fff, 1'b0);
    push_word(16'h7fff, 1'b1);
    push_word(16'h8000, 1'b1);
    push_word(16'h7fff, 1'b0);
    drain();

    if (expected_mix.size() != 0) begin
      err_count++;
      $display("%0d expected results never arrived", expected_mix.size());
    end
    $display("Run covered %0d words in %0d renormalized blocks under %0d step settings.",
             words_accepted, blocks_seen, settings_written);
    $display("%0d results checked, %0d failures found.", results_seen, err_count);
    if (err_count == 0)
      $display("[recursive_iq_mixer_core] OK");
    else
      $display("[recursive_iq_mixer_core] ERROR");
    $finish;
  end

  // Hard limit on run time in case the block hangs.
  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("Timeout after %0d cycles", LIMIT_CYCLES);
    $display("[recursive_iq_mixer_core] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
hdl/rim_pkg.sv
hdl/rim_dp.sv
hdl/rim_ctrl.sv
hdl/recursive_iq_mixer_core.sv
hdl/rim_checker.sv
tb/tb.sv
